/* rtl/hall_six_step_commutator_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the Hall six-step commutator
// Compact concurrent assertion forms that can be compiled out with ASSERT_OFF.
// ---------------------------------------------------------------------------
`ifndef HALL_SIX_STEP_COMMUTATOR_MACROS_SVH
`define HALL_SIX_STEP_COMMUTATOR_MACROS_SVH

`ifndef ASSERT_OFF

// The expression holds at every clock edge outside reset.
`define HSSC_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// The consequent holds whenever the antecedent holds.
`define HSSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define HSSC_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define HSSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/hssc_pkg.sv */
// ---------------------------------------------------------------------------
// Hall six-step commutator package
// Event codes, register indexes, widths, reset values and the step tables.
// ---------------------------------------------------------------------------
package hssc_pkg;

    // Field and register widths.
    localparam int unsigned OpW     = 2;
    localparam int unsigned HallW   = 3;
    localparam int unsigned PhaseW  = 3;
    localparam int unsigned DutyW   = 7;
    localparam int unsigned CountW  = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned ProdW   = CountW + DutyW;

    // Division by one hundred through a reciprocal multiply.
    localparam int unsigned RecipShift = 30;
    localparam int unsigned RecipW     = 24;
    localparam logic [RecipW-1:0] Recip100 = RecipW'((64'd1 << RecipShift) / 64'd100 + 64'd1);
    localparam int unsigned QuotW      = ProdW + RecipW;

    localparam logic [DutyW-1:0]  DutyMax       = DutyW'(100);
    localparam logic [CountW-1:0] CountSat      = '1;

    // Register reset values.
    localparam logic [DutyW-1:0]  DutyReset     = DutyW'(15);
    localparam logic              DirReset      = 1'b0;
    localparam logic [CountW-1:0] PeriodReset   = CountW'(1000);
    localparam logic [CountW-1:0] LimitReset    = CountW'(2000);

    // Event kinds.
    typedef enum logic [OpW-1:0] {
        OP_TICK  = 2'd0,
        OP_HALL  = 2'd1,
        OP_START = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    // Configuration register indexes.
    typedef enum logic [CfgIdxW-1:0] {
        CFG_DUTY   = 2'd0,
        CFG_DIR    = 2'd1,
        CFG_PERIOD = 2'd2,
        CFG_LIMIT  = 2'd3
    } cfg_idx_t;

    // Phase masks.
    localparam logic [PhaseW-1:0] PhA  = 3'b001;
    localparam logic [PhaseW-1:0] PhB  = 3'b010;
    localparam logic [PhaseW-1:0] PhC  = 3'b100;
    localparam logic [PhaseW-1:0] PhNone = 3'b000;

    // High-side phase driven with PWM for each step.
    function automatic logic [PhaseW-1:0] step_high(input logic [HallW-1:0] step);
        logic [PhaseW-1:0] mask;
        case (step)
            3'd1:    mask = PhC;
            3'd2:    mask = PhA;
            3'd3:    mask = PhC;
            3'd4:    mask = PhB;
            3'd5:    mask = PhB;
            3'd6:    mask = PhA;
            default: mask = PhNone;
        endcase
        return mask;
    endfunction

    // Low-side phase held fully on for each step.
    function automatic logic [PhaseW-1:0] step_low(input logic [HallW-1:0] step);
        logic [PhaseW-1:0] mask;
        case (step)
            3'd1:    mask = PhA;
            3'd2:    mask = PhB;
            3'd3:    mask = PhB;
            3'd4:    mask = PhC;
            3'd5:    mask = PhA;
            3'd6:    mask = PhC;
            default: mask = PhNone;
        endcase
        return mask;
    endfunction

endpackage

/* rtl/hall_six_step_commutator.sv */
// ---------------------------------------------------------------------------
// Hall six-step commutator
// Turns tick, Hall change, start and stop events into phase enables and PWM
// compare values for a brushless motor, with stall detection on ticks.
// ---------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  input    | in_valid / in_stall  | opcode, hall_bits
//  output   | out_valid / out_stall| high_enable, low_enable, compare_a/b/c,
//           |                      | running, stalled
//  config   | cfg_we               | cfg_index, cfg_data
//
// One event beat is accepted per cycle while in_stall is low; its result
// beat comes from the third register (duty product register,
// divide-by-100 register, state and result register). The two multipliers
// set the depth; all motor state sits in the last stage, so back-to-back
// events never wait on each other.
// Reset clears the valid bits and motor state and loads the register defaults; no clearing pass.
// A stalled result holds the last stage; the earlier stages keep filling
// until full, then in_stall rises.
`include "hall_six_step_commutator_macros.svh"

module hall_six_step_commutator (
    input  logic                          clk,
    input  logic                          rst_n,
    // Event input.
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [hssc_pkg::OpW-1:0]      opcode,
    input  logic [hssc_pkg::HallW-1:0]    hall_bits,
    // Result output.
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [hssc_pkg::PhaseW-1:0]   high_enable,
    output logic [hssc_pkg::PhaseW-1:0]   low_enable,
    output logic [hssc_pkg::CountW-1:0]   compare_a,
    output logic [hssc_pkg::CountW-1:0]   compare_b,
    output logic [hssc_pkg::CountW-1:0]   compare_c,
    output logic                          running,
    output logic                          stalled,
    // Configuration writes.
    input  logic                          cfg_we,
    input  logic [hssc_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [hssc_pkg::CfgW-1:0]     cfg_data
);

    // Configuration registers.
    logic [hssc_pkg::DutyW-1:0]  duty_reg;
    logic                        dir_reg;
    logic [hssc_pkg::CountW-1:0] period_reg;
    logic [hssc_pkg::CountW-1:0] limit_reg;

    // Pipeline registers.
    logic                        s1_valid_reg;
    logic [hssc_pkg::OpW-1:0]    s1_op_reg;
    logic [hssc_pkg::HallW-1:0]  s1_hall_reg;
    logic [hssc_pkg::ProdW-1:0]  s1_prod_reg;
    logic                        s2_valid_reg;
    logic [hssc_pkg::OpW-1:0]    s2_op_reg;
    logic [hssc_pkg::HallW-1:0]  s2_hall_reg;
    logic [hssc_pkg::CountW-1:0] s2_pwm_reg;
    logic                        out_valid_reg;

    // Motor state, which is also the result.
    logic                        run_reg,     run_next;
    logic [hssc_pkg::CountW-1:0] count_reg,   count_next;
    logic [hssc_pkg::PhaseW-1:0] high_reg,    high_next;
    logic [hssc_pkg::PhaseW-1:0] low_reg,     low_next;
    logic [hssc_pkg::CountW-1:0] cmp_reg  [3];
    logic [hssc_pkg::CountW-1:0] cmp_next [3];
    logic                        stalled_reg, stalled_next;

    logic                        out_free;
    logic                        s2_free;
    logic                        s1_free;
    logic                        s3_load;
    logic [hssc_pkg::DutyW-1:0]  duty_clamped;
    logic [hssc_pkg::QuotW-1:0]  quot_full;
    logic [hssc_pkg::HallW-1:0]  step;
    logic [hssc_pkg::PhaseW-1:0] step_high;
    logic [hssc_pkg::PhaseW-1:0] step_low;
    logic [hssc_pkg::CountW-1:0] count_inc;
    logic                        do_comm;

    // Flow control: each stage moves when the one after it has room.
    assign out_free = !out_valid_reg || !out_stall;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s3_load  = s2_valid_reg && out_free;
    assign in_stall = !s1_free;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg   <= hssc_pkg::DutyReset;
            dir_reg    <= hssc_pkg::DirReset;
            period_reg <= hssc_pkg::PeriodReset;
            limit_reg  <= hssc_pkg::LimitReset;
        end
        else if (cfg_we)
        begin
            case (hssc_pkg::cfg_idx_t'(cfg_index))
                hssc_pkg::CFG_DUTY:   duty_reg   <= cfg_data[hssc_pkg::DutyW-1:0];
                hssc_pkg::CFG_DIR:    dir_reg    <= cfg_data[0];
                hssc_pkg::CFG_PERIOD: period_reg <= cfg_data;
                hssc_pkg::CFG_LIMIT:  limit_reg  <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Duty clamp and the period times duty product.
    assign duty_clamped = (duty_reg > hssc_pkg::DutyMax) ? hssc_pkg::DutyMax : duty_reg;

    always_ff @(posedge clk)
    begin
        if (s1_free)
        begin
            s1_op_reg   <= opcode;
            s1_hall_reg <= hall_bits;
            s1_prod_reg <= hssc_pkg::ProdW'(period_reg) * hssc_pkg::ProdW'(duty_clamped);
        end
    end

    // Divide the product by one hundred with a reciprocal multiply.
    assign quot_full = hssc_pkg::QuotW'(s1_prod_reg) * hssc_pkg::QuotW'(hssc_pkg::Recip100);

    always_ff @(posedge clk)
    begin
        if (s2_free)
        begin
            s2_op_reg   <= s1_op_reg;
            s2_hall_reg <= s1_hall_reg;
            s2_pwm_reg  <= quot_full[hssc_pkg::RecipShift +: hssc_pkg::CountW];
        end
    end

    // Step lookup; with dir_reg clear the step is seven minus the Hall code.
    assign step      = dir_reg ? s2_hall_reg : ~s2_hall_reg;
    assign step_high = hssc_pkg::step_high(step);
    assign step_low  = hssc_pkg::step_low(step);
    assign count_inc = (count_reg == hssc_pkg::CountSat) ? count_reg
                                                         : count_reg + 1'b1;

    // Event handling and commutation.
    always_comb
    begin
        run_next     = run_reg;
        count_next   = count_reg;
        high_next    = high_reg;
        low_next     = low_reg;
        stalled_next = 1'b0;
        do_comm      = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            cmp_next[i] = cmp_reg[i];
        end
        case (hssc_pkg::op_t'(s2_op_reg))
            hssc_pkg::OP_TICK:
            begin
                if (run_reg)
                begin
                    count_next = count_inc;
                    if (count_inc > limit_reg)
                    begin
                        run_next     = 1'b0;
                        high_next    = hssc_pkg::PhNone;
                        low_next     = hssc_pkg::PhNone;
                        stalled_next = 1'b1;
                    end
                end
            end
            hssc_pkg::OP_HALL:
            begin
                do_comm = run_reg;
            end
            hssc_pkg::OP_START:
            begin
                if (!run_reg)
                begin
                    run_next = 1'b1;
                    do_comm  = 1'b1;
                end
            end
            default:
            begin
                run_next  = 1'b0;
                high_next = hssc_pkg::PhNone;
                low_next  = hssc_pkg::PhNone;
            end
        endcase
        // Commutation clears the count and loads the enables and the compares of driven phases.
        if (do_comm)
        begin
            count_next = '0;
            high_next  = step_high;
            low_next   = step_low;
            for (int i = 0; i < 3; i++)
            begin
                if (step_high[i])
                begin
                    cmp_next[i] = s2_pwm_reg;
                end
                else if (step_low[i])
                begin
                    cmp_next[i] = period_reg;
                end
            end
        end
    end

    // Motor state and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg     <= 1'b0;
            count_reg   <= '0;
            high_reg    <= hssc_pkg::PhNone;
            low_reg     <= hssc_pkg::PhNone;
            stalled_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                cmp_reg[i] <= '0;
            end
        end
        else if (s3_load)
        begin
            run_reg     <= run_next;
            count_reg   <= count_next;
            high_reg    <= high_next;
            low_reg     <= low_next;
            stalled_reg <= stalled_next;
            for (int i = 0; i < 3; i++)
            begin
                cmp_reg[i] <= cmp_next[i];
            end
        end
    end

    // Result beat.
    assign out_valid   = out_valid_reg;
    assign high_enable = high_reg;
    assign low_enable  = low_reg;
    assign compare_a   = cmp_reg[0];
    assign compare_b   = cmp_reg[1];
    assign compare_c   = cmp_reg[2];
    assign running     = run_reg;
    assign stalled     = stalled_reg;

    // A stopped motor has every switch off.
    `HSSC_ASSERT_IMPLIES(a_stopped_off, clk, rst_n, !running,
        (high_enable == hssc_pkg::PhNone) && (low_enable == hssc_pkg::PhNone))
    // A stall result always shows the motor stopped.
    `HSSC_ASSERT_IMPLIES(a_stall_stops, clk, rst_n, stalled, !running)
    // At most one phase per side, and never both switches of one phase.
    `HSSC_ASSERT_ALWAYS(a_one_high, clk, rst_n, $onehot0(high_enable))
    `HSSC_ASSERT_ALWAYS(a_one_low, clk, rst_n, $onehot0(low_enable))
    `HSSC_ASSERT_ALWAYS(a_no_shoot, clk, rst_n, (high_enable & low_enable) == 3'b000)

endmodule
